// ===== rtl/lmrs_pkg.sv =====
// Shared types, codes and sizing constants for the led matrix row shift driver.
// Used by every module of the block; depends on nothing else.
package lmrs_pkg;

  localparam int MATRIX_SIZE = 8;
  localparam int COLOR_BITS  = 8;
  localparam int GAMMA_BITS  = 6;

  localparam int GAMMA_REG_W = 6;
  localparam int LINE_W      = 8;
  localparam int SHIFT_W     = (COLOR_BITS > GAMMA_BITS) ? COLOR_BITS : GAMMA_BITS;
  localparam int BIT_W       = $clog2(SHIFT_W);
  localparam int PIX_W       = $clog2(MATRIX_SIZE);
  localparam int FS_DEPTH    = MATRIX_SIZE * MATRIX_SIZE;
  localparam int FS_AW       = $clog2(FS_DEPTH);
  localparam int EXT_W       = 16;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  // action codes of the input item
  localparam logic [2:0] ACT_WRITE_PIXEL = 3'd0;
  localparam logic [2:0] ACT_SEND_ROW    = 3'd1;
  localparam logic [2:0] ACT_SEND_GAMMA  = 3'd2;
  localparam logic [2:0] ACT_SELECT_LINE = 3'd3;
  localparam logic [2:0] ACT_LINES_OFF   = 3'd4;
  localparam logic [2:0] ACT_TICK        = 3'd5;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_GAMMA_BLUE  = 2'd0;
  localparam logic [1:0] REG_GAMMA_GREEN = 2'd1;
  localparam logic [1:0] REG_GAMMA_RED   = 2'd2;

  localparam logic [GAMMA_REG_W-1:0] GAMMA_RESET = GAMMA_REG_W'(63);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_SEND_ROW,
    OP_SEND_GAMMA,
    OP_SELECT,
    OP_LINES_OFF,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DATA,
    MODE_GAMMA,
    MODE_LATCH
  } mode_t;

  typedef enum logic [1:0] {
    COL_BLUE,
    COL_GREEN,
    COL_RED
  } color_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] col_index;
    logic [2:0] row_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic       serial_data;
    logic       shift_clock;
    logic       latch_pulse;
    logic       bank_select;
    logic [7:0] line_enables;
    logic       busy_res;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    op_t              op;
    logic             idx_ok;
    logic [2:0]       col;
    logic [FS_AW-1:0] addr;
    pixel_t           pix;
  } cmd_t;

  typedef struct packed {
    logic [GAMMA_REG_W-1:0] blue;
    logic [GAMMA_REG_W-1:0] green;
    logic [GAMMA_REG_W-1:0] red;
  } gamma_cfg_t;

  function automatic logic [FS_AW-1:0] fs_addr(logic [2:0] col, logic [PIX_W-1:0] row);
    logic [EXT_W-1:0] sum;
    sum = EXT_W'(col) * EXT_W'(MATRIX_SIZE) + EXT_W'(row);
    return sum[FS_AW-1:0];
  endfunction

  // gamma word placed at the top of the shift register, low GAMMA_BITS kept
  function automatic logic [SHIFT_W-1:0] gamma_align(logic [GAMMA_REG_W-1:0] g);
    logic [EXT_W-1:0]   ext;
    logic [SHIFT_W-1:0] w;
    ext = EXT_W'(g);
    w   = SHIFT_W'(ext[GAMMA_BITS-1:0]);
    return w << (SHIFT_W - GAMMA_BITS);
  endfunction

  function automatic logic [SHIFT_W-1:0] color_align(logic [COLOR_BITS-1:0] c);
    logic [SHIFT_W-1:0] w;
    w = SHIFT_W'(c);
    return w << (SHIFT_W - COLOR_BITS);
  endfunction

endpackage

// ===== rtl/lmrs_front.sv =====
// Front end: decodes an incoming item into a command with range checks done.
// Depends on lmrs_pkg.
module lmrs_front (
  input  lmrs_pkg::in_t  in_data,
  output lmrs_pkg::cmd_t cmd
);
  import lmrs_pkg::*;

  logic col_ok;
  logic row_ok;

  assign col_ok = (int'(in_data.col_index) < MATRIX_SIZE);
  assign row_ok = (int'(in_data.row_index) < MATRIX_SIZE);

  always_comb begin
    cmd        = '0;
    cmd.col    = in_data.col_index;
    cmd.addr   = fs_addr(in_data.col_index, PIX_W'(in_data.row_index));
    cmd.pix.red   = COLOR_BITS'(in_data.red);
    cmd.pix.green = COLOR_BITS'(in_data.green);
    cmd.pix.blue  = COLOR_BITS'(in_data.blue);
    cmd.idx_ok = col_ok;
    case (in_data.action)
      ACT_WRITE_PIXEL: begin
        cmd.op     = OP_WRITE;
        cmd.idx_ok = col_ok && row_ok;
      end
      ACT_SEND_ROW:    cmd.op = OP_SEND_ROW;
      ACT_SEND_GAMMA:  cmd.op = OP_SEND_GAMMA;
      ACT_SELECT_LINE: cmd.op = OP_SELECT;
      ACT_LINES_OFF:   cmd.op = OP_LINES_OFF;
      ACT_TICK:        cmd.op = OP_TICK;
      default:         cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/lmrs_queue.sv =====
// Short command queue between the front end and the shift engine.
// Depends on lmrs_pkg.
module lmrs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmrs_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output lmrs_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import lmrs_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/lmrs_back.sv =====
// Shift engine: frame store, bit sequencer, line register and result register.
// Depends on lmrs_pkg; fed by lmrs_queue.
module lmrs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lmrs_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  lmrs_pkg::gamma_cfg_t gamma,
  output logic                out_valid,
  output lmrs_pkg::out_t      out_data,
  input  logic                out_stall
);
  import lmrs_pkg::*;

  localparam logic [BIT_W-1:0] DATA_LAST_BIT  = BIT_W'(COLOR_BITS - 1);
  localparam logic [BIT_W-1:0] GAMMA_LAST_BIT = BIT_W'(GAMMA_BITS - 1);
  localparam logic [PIX_W-1:0] LAST_PIX       = PIX_W'(MATRIX_SIZE - 1);

  mode_t              mode_r, mode_nxt;
  logic               bank_r, bank_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  color_t             color_r, color_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic [2:0]         col_r, col_nxt;
  logic               out_valid_r;
  out_t               out_data_r, out_data_nxt;

  pixel_t             fs_mem [FS_DEPTH];
  logic [FS_DEPTH-1:0] fs_vld_r;
  pixel_t             fs_rdata_r;
  logic               fs_rvld_r;
  pixel_t             fs_pix;
  logic               fs_we;
  logic               fs_re;
  logic [FS_AW-1:0]   fs_raddr;

  logic               fire;
  logic               busy;
  logic               blocked;
  logic               shifting;
  logic               is_data;
  logic [BIT_W-1:0]   last_bit;
  logic               seq_done;
  logic [SHIFT_W-1:0] word;

  assign fire     = q_valid && (!out_valid_r || !out_stall);
  assign q_pop    = fire;
  assign busy     = (mode_r != MODE_IDLE);
  assign blocked  = busy && (q_cmd.op != OP_TICK) && (q_cmd.op != OP_NOP);
  assign shifting = (mode_r == MODE_DATA) || (mode_r == MODE_GAMMA);
  assign is_data  = (mode_r == MODE_DATA);
  assign last_bit = is_data ? DATA_LAST_BIT : GAMMA_LAST_BIT;
  assign seq_done = (bit_r == last_bit) && (color_r == COL_RED) && (pix_r == LAST_PIX);
  assign fs_pix   = fs_rvld_r ? fs_rdata_r : '0;

  // sequencer next state
  always_comb begin
    mode_nxt = mode_r;
    if (fire && !blocked) begin
      case (q_cmd.op)
        OP_SEND_ROW:   mode_nxt = q_cmd.idx_ok ? MODE_DATA : mode_r;
        OP_SEND_GAMMA: mode_nxt = MODE_GAMMA;
        OP_TICK: begin
          case (mode_r)
            MODE_LATCH: mode_nxt = MODE_IDLE;
            MODE_DATA:  mode_nxt = seq_done ? MODE_LATCH : MODE_DATA;
            MODE_GAMMA: mode_nxt = seq_done ? MODE_IDLE : MODE_GAMMA;
            default:    mode_nxt = mode_r;
          endcase
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // word loaded at the start of each color, otherwise keep shifting
  always_comb begin
    word = shift_r;
    if (bit_r == '0) begin
      if (is_data) begin
        case (color_r)
          COL_BLUE:  word = color_align(fs_pix.blue);
          COL_GREEN: word = color_align(fs_pix.green);
          COL_RED:   word = color_align(fs_pix.red);
          default:   word = '0;
        endcase
      end else begin
        case (color_r)
          COL_BLUE:  word = gamma_align(gamma.blue);
          COL_GREEN: word = gamma_align(gamma.green);
          COL_RED:   word = gamma_align(gamma.red);
          default:   word = '0;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    bank_nxt     = bank_r;
    line_nxt     = line_r;
    shift_nxt    = shift_r;
    bit_nxt      = bit_r;
    color_nxt    = color_r;
    pix_nxt      = pix_r;
    col_nxt      = col_r;
    fs_we        = 1'b0;
    fs_re        = 1'b0;
    fs_raddr     = fs_addr(q_cmd.col, '0);
    out_data_nxt = '0;
    if (fire) begin
      if (blocked) begin
        out_data_nxt.rejected = 1'b1;
      end else begin
        case (q_cmd.op)
          OP_WRITE: fs_we = q_cmd.idx_ok;
          OP_SEND_ROW: begin
            if (q_cmd.idx_ok) begin
              col_nxt   = q_cmd.col;
              bit_nxt   = '0;
              color_nxt = COL_BLUE;
              pix_nxt   = '0;
              shift_nxt = '0;
              fs_re     = 1'b1;
            end
          end
          OP_SEND_GAMMA: begin
            bank_nxt  = 1'b0;
            bit_nxt   = '0;
            color_nxt = COL_BLUE;
            pix_nxt   = '0;
            shift_nxt = '0;
          end
          OP_SELECT:    line_nxt = q_cmd.idx_ok ? (LINE_W'(1) << q_cmd.col) : '0;
          OP_LINES_OFF: line_nxt = '0;
          OP_TICK: begin
            if (mode_r == MODE_LATCH) begin
              out_data_nxt.latch_pulse = 1'b1;
            end else if (shifting) begin
              out_data_nxt.serial_data = word[SHIFT_W-1];
              out_data_nxt.shift_clock = 1'b1;
              shift_nxt = word << 1;
              // fetch the next pixel while its red byte is still ahead
              if (is_data && (bit_r == '0) && (color_r == COL_RED) && (pix_r != LAST_PIX)) begin
                fs_re    = 1'b1;
                fs_raddr = fs_addr(col_r, pix_r + 1'b1);
              end
              if (bit_r == last_bit) begin
                bit_nxt = '0;
                case (color_r)
                  COL_BLUE:  color_nxt = COL_GREEN;
                  COL_GREEN: color_nxt = COL_RED;
                  default: begin
                    color_nxt = COL_BLUE;
                    pix_nxt   = (pix_r == LAST_PIX) ? '0 : pix_r + 1'b1;
                  end
                endcase
                if (seq_done && !is_data) begin
                  bank_nxt = 1'b1;
                end
              end else begin
                bit_nxt = bit_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      out_data_nxt.bank_select  = bank_nxt;
      out_data_nxt.line_enables = line_nxt;
      out_data_nxt.busy_res     = (mode_nxt != MODE_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      bank_r      <= 1'b0;
      line_r      <= '0;
      shift_r     <= '0;
      bit_r       <= '0;
      color_r     <= COL_BLUE;
      pix_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      fs_vld_r    <= '0;
      fs_rvld_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      bank_r  <= bank_nxt;
      line_r  <= line_nxt;
      shift_r <= shift_nxt;
      bit_r   <= bit_nxt;
      color_r <= color_nxt;
      pix_r   <= pix_nxt;
      col_r   <= col_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fs_we) begin
        fs_vld_r[q_cmd.addr] <= 1'b1;
      end
      if (fs_re) begin
        fs_rvld_r <= fs_vld_r[fs_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // frame store, registered read port
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[q_cmd.addr] <= q_cmd.pix;
    end
    if (fs_re) begin
      fs_rdata_r <= fs_mem[fs_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/led_matrix_row_shift_driver_core.sv =====
// Driver for an 8x8 RGB led matrix behind a constant-current shift-register chip. Every
// accepted item gives exactly one result, in order. One item is taken per clock for as
// long as results are taken. Each accepted item is registered in the command queue, then
// lands in the shift engine's result register, where out_valid rises; a stall on the
// output can hold it in the queue before that. The frame store is cleared at reset by
// per-pixel valid bits, so there is no clearing pass and items are accepted right after
// reset. Gamma words are set through the cfg_ port.
// Depends on lmrs_pkg, lmrs_front, lmrs_queue and lmrs_back.
module led_matrix_row_shift_driver_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lmrs_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lmrs_pkg::out_t                out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lmrs_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [lmrs_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [lmrs_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import lmrs_pkg::*;

  gamma_cfg_t gamma_r, gamma_nxt;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       q_full;
  logic       head_valid;
  logic       q_pop;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    gamma_nxt = gamma_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_GAMMA_BLUE:  gamma_nxt.blue  = cfg_pwdata[GAMMA_REG_W-1:0];
        REG_GAMMA_GREEN: gamma_nxt.green = cfg_pwdata[GAMMA_REG_W-1:0];
        REG_GAMMA_RED:   gamma_nxt.red   = cfg_pwdata[GAMMA_REG_W-1:0];
        default:         gamma_nxt = gamma_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAMMA_BLUE:  cfg_prdata = APB_DW'(gamma_r.blue);
      REG_GAMMA_GREEN: cfg_prdata = APB_DW'(gamma_r.green);
      REG_GAMMA_RED:   cfg_prdata = APB_DW'(gamma_r.red);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r.blue  <= GAMMA_RESET;
      gamma_r.green <= GAMMA_RESET;
      gamma_r.red   <= GAMMA_RESET;
    end else begin
      gamma_r <= gamma_nxt;
    end
  end

  assign in_stall = q_full;

  lmrs_front u_front (
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  lmrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  lmrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .gamma     (gamma_r),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
